// File: design/ftrb_pkg.sv
// Shared types and constants of the filtered trace ring buffer.
// Depends on nothing; every other design file refers to it by scoped names.
package ftrb_pkg;

  localparam int DefRingDepth = 256;

  typedef enum logic [2:0] {
    ACT_RECORD = 3'd0,
    ACT_STAMP  = 3'd1,
    ACT_EXIT   = 3'd2,
    ACT_SET    = 3'd3,
    ACT_READ   = 3'd4
  } action_e;

  typedef struct packed {
    logic [2:0]         action;
    logic [31:0]        src_id;
    logic [31:0]        event_code;
    logic [63:0]        arg_one;
    logic [63:0]        arg_two;
    logic [63:0]        arg_three;
    logic [63:0]        arg_four;
    logic signed [63:0] ret_value;
    logic [31:0]        seq_index;
  } in_t;

  typedef struct packed {
    logic               status;
    logic [31:0]        out_seq;
    logic [31:0]        out_id;
    logic [31:0]        out_code;
    logic               out_exited;
    logic [63:0]        out_arg_one;
    logic [63:0]        out_arg_two;
    logic [63:0]        out_arg_three;
    logic [63:0]        out_arg_four;
    logic signed [63:0] out_ret;
  } out_t;

  // One ring slot, without its return value, which lives in a memory of its own.
  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] id;
    logic [31:0] code;
    logic        exited;
    logic [63:0] arg_one;
    logic [63:0] arg_two;
    logic [63:0] arg_three;
    logic [63:0] arg_four;
  } entry_t;

  // Memory access request from the controller to the slot store.
  typedef struct packed {
    logic wr_main;
    logic wr_ret;
    logic rd_en;
  } mem_req_t;

endpackage

// File: design/ftrb_slot_mod.sv
// Three-stage reduction of a 32-bit sequence number to its ring slot.
// Depends on ftrb_pkg only through the parameter default.
module ftrb_slot_mod #(
  parameter int RING_DEPTH = ftrb_pkg::DefRingDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [31:0]                   seq_i,
  output logic                          done_o,
  output logic [$clog2(RING_DEPTH)-1:0] slot_o
);

  localparam int AW = $clog2(RING_DEPTH);
  // Reciprocal rounded down: the quotient estimate is exact or one short.
  localparam logic [32:0] RecipM = 33'((64'd1 << (32 + AW)) / 64'(RING_DEPTH));
  localparam logic [AW:0] DepthN = (AW + 1)'(RING_DEPTH);

  logic          v1_q, v2_q, v3_q;
  logic [AW:0]   x1_q, x2_q;
  logic [AW:0]   q1_q;
  logic [AW:0]   p2_q;
  logic [AW-1:0] slot_q;
  logic [64:0]   prod1;
  logic [2*AW+1:0] prod2;
  logic [AW:0]   rem_raw;
  logic [AW:0]   rem_fix;

  // Only the low bits of quotient and product matter: the remainder is below 2*depth.
  assign prod1   = 65'(seq_i) * 65'(RecipM);
  assign prod2   = q1_q * DepthN;
  assign rem_raw = x2_q - p2_q;
  assign rem_fix = (rem_raw >= DepthN) ? (rem_raw - DepthN) : rem_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    q1_q   <= prod1[32+AW +: AW+1];
    x1_q   <= seq_i[AW:0];
    p2_q   <= prod2[AW:0];
    x2_q   <= x1_q;
    slot_q <= rem_fix[AW-1:0];
  end

  assign done_o = v3_q;
  assign slot_o = slot_q;

endmodule

// File: design/ftrb_store.sv
// Ring slot storage: a main memory for the recorded fields and a return-value memory.
// Depends on ftrb_pkg for the slot and request types.
module ftrb_store #(
  parameter int RING_DEPTH = ftrb_pkg::DefRingDepth
) (
  input  logic                          clk_i,
  input  ftrb_pkg::mem_req_t            req_i,
  input  logic [$clog2(RING_DEPTH)-1:0] addr_i,
  input  ftrb_pkg::entry_t              wr_entry_i,
  input  logic [63:0]                   wr_ret_i,
  output ftrb_pkg::entry_t              rd_entry_o,
  output logic [63:0]                   rd_ret_o
);

  ftrb_pkg::entry_t main_mem [RING_DEPTH];
  logic [63:0]      ret_mem  [RING_DEPTH];
  ftrb_pkg::entry_t rd_entry_q;
  logic [63:0]      rd_ret_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_main) begin
      main_mem[addr_i] <= wr_entry_i;
    end
    if (req_i.rd_en) begin
      rd_entry_q <= main_mem[addr_i];
    end
  end

  // Stamps write this memory alone, so it is kept apart from the main one.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_ret) begin
      ret_mem[addr_i] <= wr_ret_i;
    end
    if (req_i.rd_en) begin
      rd_ret_q <= ret_mem[addr_i];
    end
  end

  assign rd_entry_o = rd_entry_q;
  assign rd_ret_o   = rd_ret_q;

endmodule

// File: design/filtered_trace_ring_buffer.sv
// Top level of the filtered trace ring buffer: control, state registers, output register.
// Depends on ftrb_pkg, ftrb_slot_mod and ftrb_store.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-------------------------
//   in      | input     | in_valid_i / in_ready_o    | in_data_i  (ftrb_pkg::in_t)
//   out     | output    | out_valid_o / out_ready_i  | out_data_o (ftrb_pkg::out_t)
//
// Record, exit, set-target, filtered and rejected beats go from acceptance
// through S_RESP back to idle; stamp and read beats that pass their bound first
// wait in S_MOD for the three-stage reduction of seq_index to a slot and the memory access.
// Reset (asynchronous, active low) clears the target, the sequence and all
// control state; the slot memories are not cleared and hold nothing valid.
// A result waiting in the output register does not stop the next input beat;
// only the hand-over of a new result waits for the output register to drain.
module filtered_trace_ring_buffer #(
  parameter int RING_DEPTH = ftrb_pkg::DefRingDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ftrb_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ftrb_pkg::out_t  out_data_o
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam logic [AW-1:0] SlotLast = AW'(RING_DEPTH - 1);
  localparam logic [31:0]   DepthW   = 32'(RING_DEPTH);

  // Controller states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MOD  = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [31:0] target_q, target_d;
  logic [31:0] next_seq_q, next_seq_d;
  // Slot of next_seq_q, tracked incrementally so records need no reduction.
  logic [AW-1:0] next_slot_q, next_slot_d;

  ftrb_pkg::in_t item_q;
  logic          res_status_q, res_status_d;
  logic [31:0]   res_seq_q, res_seq_d;
  logic          res_read_q, res_read_d;

  ftrb_pkg::out_t out_q;
  logic           out_valid_q;

  logic          in_fire;
  logic          id_hit;
  logic          seq_below;
  logic          read_ok;
  logic [31:0]   seq_dist;
  logic          mod_start;
  logic          mod_done;
  logic [AW-1:0] mod_slot;
  logic          out_load;

  ftrb_pkg::mem_req_t mem_req;
  logic [AW-1:0]      mem_addr;
  ftrb_pkg::entry_t   wr_entry;
  logic [63:0]        wr_ret;
  ftrb_pkg::entry_t   rd_entry;
  logic [63:0]        rd_ret;
  ftrb_pkg::out_t     out_next;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;

  // An event passes the filter only while tracing is on and its id is the target.
  assign id_hit    = (target_q != 32'd0) && (in_data_i.src_id == target_q);
  assign seq_below = (in_data_i.seq_index < next_seq_q);
  assign seq_dist  = next_seq_q - in_data_i.seq_index;
  assign read_ok   = seq_below && (seq_dist <= DepthW);

  always_comb begin
    state_d      = state_q;
    target_d     = target_q;
    next_seq_d   = next_seq_q;
    next_slot_d  = next_slot_q;
    res_status_d = res_status_q;
    res_seq_d    = res_seq_q;
    res_read_d   = res_read_q;
    mod_start    = 1'b0;
    mem_req      = '0;
    mem_addr     = next_slot_q;
    wr_entry     = '0;
    wr_ret       = 64'd0;
    out_load     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          res_status_d = 1'b1;
          res_seq_d    = 32'd0;
          res_read_d   = 1'b0;
          state_d      = S_RESP;
          case (in_data_i.action)
            ftrb_pkg::ACT_RECORD, ftrb_pkg::ACT_EXIT: begin
              wr_entry.seq    = next_seq_q;
              wr_entry.id     = in_data_i.src_id;
              wr_entry.exited = (in_data_i.action == ftrb_pkg::ACT_EXIT);
              if (in_data_i.action == ftrb_pkg::ACT_RECORD) begin
                wr_entry.code      = in_data_i.event_code;
                wr_entry.arg_one   = in_data_i.arg_one;
                wr_entry.arg_two   = in_data_i.arg_two;
                wr_entry.arg_three = in_data_i.arg_three;
                wr_entry.arg_four  = in_data_i.arg_four;
              end else begin
                wr_ret = in_data_i.ret_value;
              end
              if (id_hit) begin
                mem_req.wr_main = 1'b1;
                mem_req.wr_ret  = 1'b1;
                res_status_d    = 1'b0;
                res_seq_d       = next_seq_q;
                next_seq_d      = next_seq_q + 32'd1;
                // The sequence wraps at 32 bits, and its slot wraps with it.
                if (next_seq_q == '1 || next_slot_q == SlotLast) begin
                  next_slot_d = '0;
                end else begin
                  next_slot_d = next_slot_q + AW'(1);
                end
              end
              // An exit marker of the target ends tracing, recorded or not.
              if (in_data_i.action == ftrb_pkg::ACT_EXIT &&
                  in_data_i.src_id == target_q) begin
                target_d = 32'd0;
              end
            end
            ftrb_pkg::ACT_STAMP: begin
              if (seq_below) begin
                mod_start = 1'b1;
                state_d   = S_MOD;
              end
            end
            ftrb_pkg::ACT_SET: begin
              target_d     = in_data_i.src_id;
              res_status_d = 1'b0;
              if (in_data_i.src_id != 32'd0) begin
                next_seq_d  = 32'd0;
                next_slot_d = '0;
              end
            end
            ftrb_pkg::ACT_READ: begin
              if (read_ok) begin
                mod_start = 1'b1;
                state_d   = S_MOD;
              end
            end
            default: begin
              res_status_d = 1'b1;
            end
          endcase
        end
      end
      S_MOD: begin
        mem_addr = mod_slot;
        if (mod_done) begin
          res_status_d = 1'b0;
          if (item_q.action == ftrb_pkg::ACT_STAMP) begin
            mem_req.wr_ret = 1'b1;
            wr_ret         = item_q.ret_value;
          end else begin
            mem_req.rd_en = 1'b1;
            res_read_d    = 1'b1;
          end
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      target_q     <= 32'd0;
      next_seq_q   <= 32'd0;
      next_slot_q  <= '0;
      res_status_q <= 1'b0;
      res_seq_q    <= 32'd0;
      res_read_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      target_q     <= target_d;
      next_seq_q   <= next_seq_d;
      next_slot_q  <= next_slot_d;
      res_status_q <= res_status_d;
      res_seq_q    <= res_seq_d;
      res_read_q   <= res_read_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_data_i;
    end
    if (out_load) begin
      out_q <= out_next;
    end
  end

  // Fields other than status and sequence come only from a successful read.
  always_comb begin
    out_next        = '0;
    out_next.status = res_status_q;
    out_next.out_seq = res_seq_q;
    if (res_read_q) begin
      out_next.out_seq       = rd_entry.seq;
      out_next.out_id        = rd_entry.id;
      out_next.out_code      = rd_entry.code;
      out_next.out_exited    = rd_entry.exited;
      out_next.out_arg_one   = rd_entry.arg_one;
      out_next.out_arg_two   = rd_entry.arg_two;
      out_next.out_arg_three = rd_entry.arg_three;
      out_next.out_arg_four  = rd_entry.arg_four;
      out_next.out_ret       = rd_ret;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  ftrb_slot_mod #(
    .RING_DEPTH(RING_DEPTH)
  ) u_slot_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mod_start),
    .seq_i  (in_data_i.seq_index),
    .done_o (mod_done),
    .slot_o (mod_slot)
  );

  ftrb_store #(
    .RING_DEPTH(RING_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .addr_i    (mem_addr),
    .wr_entry_i(wr_entry),
    .wr_ret_i  (wr_ret),
    .rd_entry_o(rd_entry),
    .rd_ret_o  (rd_ret)
  );

`ifndef NO_ASSERTIONS
  // The slot reduction only finishes while the controller waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> (state_q == S_MOD))
    else $error("slot reduction finished outside its wait state");

  // The store never sees a read and a write in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.rd_en |-> !(mem_req.wr_main || mem_req.wr_ret))
    else $error("slot store read and written together");

  // A recorded event advances the sequence by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && id_hit && (in_data_i.action == ftrb_pkg::ACT_RECORD ||
                           in_data_i.action == ftrb_pkg::ACT_EXIT))
    |=> (next_seq_q == $past(next_seq_q) + 32'd1))
    else $error("sequence did not advance on a recorded event");

  // A successful read finds the entry recorded under the requested sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && res_read_q) |-> (rd_entry.seq == item_q.seq_index))
    else $error("read returned an entry of another sequence");
`endif

endmodule
